FILE: hw/rtl/spwm_pkg.sv
package spwm_pkg;

    localparam int CountW = 8;
    localparam int TicksW = 10;
    localparam int PeriodW = 8;
    localparam int DigitW = 2;
    localparam int SegW = 7;
    localparam int AngleW = 8;
    localparam int CfgDataW = 10;
    localparam int CfgIdxW = 2;

    localparam logic [AngleW-1:0] AngleMax = 8'd180;

    // Register indexes on the configuration port
    typedef enum logic [CfgIdxW-1:0] {
        CFG_MIN_COUNT    = 2'd0,
        CFG_MAX_COUNT    = 2'd1,
        CFG_LOW_TICKS    = 2'd2,
        CFG_PERIODS_UPD  = 2'd3
    } cfg_idx_t;

    // Display digit positions, leftmost first
    typedef enum logic [DigitW-1:0] {
        DIG_THOUSANDS = 2'd0,
        DIG_HUNDREDS  = 2'd1,
        DIG_TENS      = 2'd2,
        DIG_ONES      = 2'd3
    } digit_pos_t;

    // Angle in degrees: (count - min) * 5 / 2, truncated, limited to 180
    function automatic logic [AngleW-1:0] angle_of(
        input logic [CountW-1:0] count,
        input logic [CountW-1:0] min_count
    );
        logic [CountW-1:0] diff;
        logic [CountW+2:0] times5;
        logic [CountW+1:0] half;
        diff   = count - min_count;
        times5 = {1'b0, diff, 2'b00} + {3'b000, diff};
        half   = times5[CountW+2:1];
        if (count < min_count) begin
            angle_of = '0;
        end else if (half > {2'b00, AngleMax}) begin
            angle_of = AngleMax;
        end else begin
            angle_of = half[AngleW-1:0];
        end
    endfunction

    // Quotient by ten for values up to 255: multiply by 205, drop 11 bits
    function automatic logic [4:0] div10(input logic [AngleW-1:0] a);
        logic [15:0] prod;
        prod = {8'd0, a} * 16'd205;
        div10 = prod[15:11];
    endfunction

    // Seven segment pattern, bit0 = a ... bit6 = g
    function automatic logic [SegW-1:0] seg_code(input logic [3:0] d);
        unique case (d)
            4'd0:    seg_code = 7'h3F;
            4'd1:    seg_code = 7'h06;
            4'd2:    seg_code = 7'h5B;
            4'd3:    seg_code = 7'h4F;
            4'd4:    seg_code = 7'h66;
            4'd5:    seg_code = 7'h6D;
            4'd6:    seg_code = 7'h7D;
            4'd7:    seg_code = 7'h07;
            4'd8:    seg_code = 7'h7F;
            4'd9:    seg_code = 7'h67;
            default: seg_code = 7'h3F;
        endcase
    endfunction

endpackage

FILE: hw/rtl/servo_pwm_with_angle_display.sv
// Servo PWM generator with a four-digit seven-segment angle display. Each
// input transaction is one timer tick (s_tick = 1) or a hold step (s_tick = 0),
// with the two button levels; every input transaction yields exactly one
// output transaction holding the servo pin level, the digit last driven, its
// segment pattern and the current angle. One transaction is taken per clock:
// the whole update is one combinational pass from the state registers into the
// output register, and the input side stays ready while the output register is
// empty or being drained, so the block sustains one tick per cycle from a
// prescaled enable. The pulse-width count is sampled from the buttons at the
// start of every burst of periods_per_update PWM periods; a period is
// pulse_count ticks high followed by low_ticks ticks low, and at the end of
// each period one digit (thousands, hundreds, tens, ones, with leading zeros)
// of the angle (count - min_count) * 5 / 2, limited to 180, is latched.
// Write the configuration registers only while no transaction is in flight.
module servo_pwm_with_angle_display (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [spwm_pkg::CfgIdxW-1:0]    cfg_addr,
    input  logic [spwm_pkg::CfgDataW-1:0]   cfg_wdata,
    // input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_tick,
    input  logic                            s_up_pressed,
    input  logic                            s_down_pressed,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_pwm_level,
    output logic [spwm_pkg::DigitW-1:0]     m_digit_index,
    output logic [spwm_pkg::SegW-1:0]       m_segments,
    output logic [spwm_pkg::AngleW-1:0]     m_angle_degrees
);
    import spwm_pkg::*;

    // Configuration registers
    logic [CountW-1:0]  min_count_reg;
    logic [CountW-1:0]  max_count_reg;
    logic [TicksW-1:0]  low_ticks_reg;
    logic [PeriodW-1:0] periods_upd_reg;

    // Generator state
    logic [CountW-1:0]  pulse_count_reg, pulse_count_next;
    logic               high_phase_reg, high_phase_next;
    logic [TicksW-1:0]  phase_ticks_reg, phase_ticks_next;
    logic [PeriodW-1:0] period_num_reg, period_num_next;
    logic [DigitW-1:0]  shown_digit_reg, shown_digit_next;
    logic [SegW-1:0]    seg_hold_reg, seg_hold_next;

    // Output register
    logic               m_valid_reg;
    logic               level_reg, level_next;
    logic [DigitW-1:0]  digit_idx_reg;
    logic [SegW-1:0]    segments_reg;
    logic [AngleW-1:0]  angle_reg, angle_next;

    logic               accept;
    logic               sample;
    logic               period_end;
    logic [CountW-1:0]  count_up;
    logic [CountW-1:0]  count_smp;
    logic               hp_eff;
    logic [TicksW-1:0]  pt_eff;
    logic [TicksW-1:0]  pt_inc;
    logic [TicksW-1:0]  low_eff;
    logic [PeriodW-1:0] ppu_eff;
    logic [PeriodW-1:0] pn_inc;
    logic [AngleW-1:0]  angle_smp;
    logic [4:0]         tens_q;
    logic [3:0]         digit_val;

    // Take a transaction while the output register is empty or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_count_reg   <= 8'd21;
            max_count_reg   <= 8'd104;
            low_ticks_reg   <= 10'd360;
            periods_upd_reg <= 8'd50;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_MIN_COUNT:   min_count_reg   <= cfg_wdata[CountW-1:0];
                CFG_MAX_COUNT:   max_count_reg   <= cfg_wdata[CountW-1:0];
                CFG_LOW_TICKS:   low_ticks_reg   <= cfg_wdata[TicksW-1:0];
                CFG_PERIODS_UPD: periods_upd_reg <= cfg_wdata[PeriodW-1:0];
                default: ;
            endcase
        end
    end

    // Zero low time or zero burst length acts as one
    assign low_eff = (low_ticks_reg == '0) ? TicksW'(1) : low_ticks_reg;
    assign ppu_eff = (periods_upd_reg == '0) ? PeriodW'(1) : periods_upd_reg;

    // Button sample at the first tick of a burst: wrap, else up then clamped down
    assign sample   = (period_num_reg == '0) && high_phase_reg && (phase_ticks_reg == '0);
    assign count_up = s_up_pressed ? pulse_count_reg + CountW'(1) : pulse_count_reg;

    always_comb begin
        if (!sample) begin
            count_smp = pulse_count_reg;
        end else if (pulse_count_reg >= max_count_reg) begin
            count_smp = min_count_reg;
        end else if (s_down_pressed && (count_up > min_count_reg)) begin
            count_smp = count_up - CountW'(1);
        end else begin
            count_smp = count_up;
        end
    end

    // Zero pulse width skips the high phase; this tick then belongs to the low phase
    assign hp_eff = high_phase_reg && (count_smp != '0);
    assign pt_eff = (high_phase_reg && !hp_eff) ? '0 : phase_ticks_reg;
    assign pt_inc = pt_eff + TicksW'(1);
    assign pn_inc = period_num_reg + PeriodW'(1);

    assign period_end = !hp_eff && (pt_inc >= low_eff);

    // Digit of the angle at the period end, with leading zeros
    assign angle_smp = angle_of(count_smp, min_count_reg);
    assign tens_q    = div10(angle_smp);

    always_comb begin
        unique case (digit_pos_t'(shown_digit_reg))
            DIG_THOUSANDS: digit_val = 4'd0;
            DIG_HUNDREDS:  digit_val = (angle_smp >= 8'd100) ? 4'd1 : 4'd0;
            DIG_TENS:      digit_val = (tens_q >= 5'd10) ? 4'(tens_q - 5'd10)
                                                         : tens_q[3:0];
            DIG_ONES:      digit_val = 4'(angle_smp - {3'b000, tens_q} * 8'd10);
            default:       digit_val = 4'd0;
        endcase
    end

    // Next state: hold everything on a hold step
    always_comb begin
        pulse_count_next = pulse_count_reg;
        high_phase_next  = high_phase_reg;
        phase_ticks_next = phase_ticks_reg;
        period_num_next  = period_num_reg;
        shown_digit_next = shown_digit_reg;
        seg_hold_next    = seg_hold_reg;
        level_next       = high_phase_reg;
        if (s_tick) begin
            pulse_count_next = count_smp;
            level_next       = hp_eff;
            if (hp_eff) begin
                if (pt_inc >= {2'b00, count_smp}) begin
                    high_phase_next  = 1'b0;
                    phase_ticks_next = '0;
                end else begin
                    high_phase_next  = 1'b1;
                    phase_ticks_next = pt_inc;
                end
            end else if (period_end) begin
                seg_hold_next    = seg_code(digit_val);
                shown_digit_next = shown_digit_reg + DigitW'(1);
                high_phase_next  = 1'b1;
                phase_ticks_next = '0;
                period_num_next  = (pn_inc >= ppu_eff) ? '0 : pn_inc;
            end else begin
                high_phase_next  = 1'b0;
                phase_ticks_next = pt_inc;
            end
        end
    end

    assign angle_next = angle_of(pulse_count_next, min_count_reg);

    // Advance state only on an accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_count_reg <= 8'd21;
            high_phase_reg  <= 1'b1;
            phase_ticks_reg <= '0;
            period_num_reg  <= '0;
            shown_digit_reg <= '0;
            seg_hold_reg    <= '0;
        end else if (accept) begin
            pulse_count_reg <= pulse_count_next;
            high_phase_reg  <= high_phase_next;
            phase_ticks_reg <= phase_ticks_next;
            period_num_reg  <= period_num_next;
            shown_digit_reg <= shown_digit_next;
            seg_hold_reg    <= seg_hold_next;
        end
    end

    // Output register: load on accept, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            level_reg     <= level_next;
            // report the digit last driven
            digit_idx_reg <= shown_digit_next - DigitW'(1);
            segments_reg  <= seg_hold_next;
            angle_reg     <= angle_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pwm_level     = level_reg;
    assign m_digit_index   = digit_idx_reg;
    assign m_segments      = segments_reg;
    assign m_angle_degrees = angle_reg;

    // An accepted transaction always leaves a result waiting
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted transaction produced no result");

    // A stalled result freezes the generator state
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> ($stable(pulse_count_reg) && $stable(phase_ticks_reg)))
        else $error("state moved while output stalled");

    // The count only changes at a button sample
    a_count_at_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !(s_tick && sample)) |=> $stable(pulse_count_reg))
        else $error("pulse count changed outside a sample");

    // The digit index only advances at a period end
    a_digit_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !(s_tick && period_end)) |=> $stable(shown_digit_reg))
        else $error("digit advanced outside a period end");

    // Reported angle never exceeds the display limit
    a_angle_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (angle_reg <= AngleMax))
        else $error("angle above limit");

endmodule

FILE: tb/sv/servo_pwm_with_angle_display_tb.sv
module servo_pwm_with_angle_display_tb;
    import spwm_pkg::*;

    // Give up on a hung run well past the slowest legal pace.
    localparam int unsigned CYCLE_LIMIT = 100000;
    // Receiver hold-off length, long enough to back the block up into its input.
    localparam int unsigned HOLD_OFF_CYCLES = 200;

    // One input transaction: a timer tick (or hold step) plus both button levels.
    typedef struct packed {
        logic tick;
        logic up;
        logic down;
    } tick_item_t;

    // What the block shows after one input transaction.
    typedef struct packed {
        logic              pwm_level;
        logic [DigitW-1:0] digit_index;
        logic [SegW-1:0]   segments;
        logic [AngleW-1:0] angle_degrees;
    } servo_view_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [CfgIdxW-1:0]  cfg_addr;
    logic [CfgDataW-1:0] cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic                s_tick;
    logic                s_up_pressed;
    logic                s_down_pressed;
    logic                m_valid;
    logic                m_ready;
    logic                m_pwm_level;
    logic [DigitW-1:0]   m_digit_index;
    logic [SegW-1:0]     m_segments;
    logic [AngleW-1:0]   m_angle_degrees;

    // Ticks waiting to be offered, and the views the block owes us, oldest first.
    tick_item_t  tick_backlog[$];
    servo_view_t pending_views[$];

    // Idle percentages for each side; changed by the sequence between phases.
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;

    // Receiver hold-off request and its countdown in the result process.
    logic        hold_off_req;
    logic        hold_off_taken;
    int unsigned hold_off_left;

    int unsigned mismatches;
    int unsigned result_count;
    int unsigned cycle_count;

    // Shadow copy of the registers.
    logic [7:0] min_reg;
    logic [7:0] max_reg;
    logic [9:0] low_reg;
    logic [7:0] ppu_reg;

    // Shadow copy of the servo and display state.
    logic [7:0] width_cnt;
    logic       in_high;
    logic [9:0] phase_cnt;
    logic [7:0] burst_cnt;
    logic [1:0] next_digit;
    logic [6:0] seg_latched;

    servo_pwm_with_angle_display dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_tick          (s_tick),
        .s_up_pressed    (s_up_pressed),
        .s_down_pressed  (s_down_pressed),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pwm_level     (m_pwm_level),
        .m_digit_index   (m_digit_index),
        .m_segments      (m_segments),
        .m_angle_degrees (m_angle_degrees)
    );

    always #2 aclk = ~aclk;

    // Angle in whole degrees for a pulse width: zero below the minimum, capped at 180.
    function automatic logic [AngleW-1:0] servo_angle(input logic [7:0] cnt,
                                                      input logic [7:0] lo);
        int unsigned deg;
        if (cnt < lo) begin
            return '0;
        end
        deg = 32'(cnt - lo) * 5 / 2;
        return (deg > 180) ? 8'd180 : deg[7:0];
    endfunction

    // Advance the shadow state by one input transaction and return the view it produces.
    function automatic servo_view_t servo_advance(input logic tk, input logic up,
                                                  input logic dn);
        servo_view_t view;
        logic        lvl;
        logic [9:0]  low_len;
        logic [7:0]  ppu_len;
        int unsigned deg;
        int unsigned dval;
        lvl = in_high;
        if (tk) begin
            // Sample the buttons on the first tick of a burst.
            if (burst_cnt == 0 && in_high && phase_cnt == 0) begin
                if (width_cnt >= max_reg) begin
                    width_cnt = min_reg;
                end else begin
                    if (up) width_cnt = width_cnt + 8'd1;
                    // Clamp the decrement at the minimum.
                    if (dn && width_cnt > min_reg) width_cnt = width_cnt - 8'd1;
                end
            end
            // A zero pulse width skips the high phase entirely.
            if (in_high && width_cnt == 0) begin
                in_high   = 1'b0;
                phase_cnt = '0;
            end
            lvl       = in_high;
            phase_cnt = phase_cnt + 10'd1;
            if (in_high) begin
                if (phase_cnt >= {2'b00, width_cnt}) begin
                    in_high   = 1'b0;
                    phase_cnt = '0;
                end
            end else begin
                low_len = (low_reg == 0) ? 10'd1 : low_reg;
                if (phase_cnt >= low_len) begin
                    // Period over: latch the next digit of the angle.
                    deg = servo_angle(width_cnt, min_reg);
                    case (digit_pos_t'(next_digit))
                        DIG_THOUSANDS: dval = deg / 1000;
                        DIG_HUNDREDS:  dval = (deg / 100) % 10;
                        DIG_TENS:      dval = (deg / 10) % 10;
                        default:       dval = deg % 10;
                    endcase
                    case (dval)
                        1:       seg_latched = 7'h06;
                        2:       seg_latched = 7'h5B;
                        3:       seg_latched = 7'h4F;
                        4:       seg_latched = 7'h66;
                        5:       seg_latched = 7'h6D;
                        6:       seg_latched = 7'h7D;
                        7:       seg_latched = 7'h07;
                        8:       seg_latched = 7'h7F;
                        9:       seg_latched = 7'h67;
                        default: seg_latched = 7'h3F;
                    endcase
                    next_digit = next_digit + 2'd1;
                    in_high    = 1'b1;
                    phase_cnt  = '0;
                    burst_cnt  = burst_cnt + 8'd1;
                    ppu_len    = (ppu_reg == 0) ? 8'd1 : ppu_reg;
                    if (burst_cnt >= ppu_len) burst_cnt = '0;
                end
            end
        end
        view.pwm_level     = lvl;
        view.digit_index   = next_digit + 2'd3;
        view.segments      = seg_latched;
        view.angle_degrees = servo_angle(width_cnt, min_reg);
        return view;
    endfunction

    // Count one field mismatch; print only the first few.
    task automatic report_field(input string field, input int unsigned want_v,
                                input int unsigned got_v);
        if (want_v != got_v) begin
            if (mismatches < 10) begin
                $display("mismatch on result %0d: %s expected %0d got %0d",
                         result_count, field, want_v, got_v);
            end
            mismatches++;
        end
    endtask

    // Input driver: predict on each accepted transaction, then offer the next
    // tick from the backlog unless this cycle idles.
    always @(posedge aclk) begin : drive_ticks
        tick_item_t nxt;
        if (!aresetn) begin
            s_valid     <= 1'b0;
            width_cnt   = 8'd21;
            in_high     = 1'b1;
            phase_cnt   = '0;
            burst_cnt   = '0;
            next_digit  = '0;
            seg_latched = '0;
        end else begin
            if (s_valid && s_ready) begin
                pending_views.push_back(servo_advance(s_tick, s_up_pressed, s_down_pressed));
            end
            // Hold the payload while a transaction waits for ready.
            if (!s_valid || s_ready) begin
                if (tick_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = tick_backlog.pop_front();
                    s_valid        <= 1'b1;
                    s_tick         <= nxt.tick;
                    s_up_pressed   <= nxt.up;
                    s_down_pressed <= nxt.down;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each accepted result with the oldest prediction,
    // then pick the next ready level, honoring a requested hold-off.
    always @(posedge aclk) begin : check_views
        servo_view_t want;
        if (!aresetn) begin
            m_ready        <= 1'b0;
            hold_off_left  = 0;
            hold_off_taken = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_views.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected result %0d: level %0d digit %0d seg %0h angle %0d",
                                 result_count, m_pwm_level, m_digit_index, m_segments,
                                 m_angle_degrees);
                    end
                    mismatches++;
                end else begin
                    want = pending_views.pop_front();
                    report_field("pwm_level", 32'(want.pwm_level), 32'(m_pwm_level));
                    report_field("digit_index", 32'(want.digit_index), 32'(m_digit_index));
                    report_field("segments", 32'(want.segments), 32'(m_segments));
                    report_field("angle_degrees", 32'(want.angle_degrees),
                                 32'(m_angle_degrees));
                end
                result_count++;
            end
            if (hold_off_req && !hold_off_taken) begin
                hold_off_taken = 1'b1;
                hold_off_left  = HOLD_OFF_CYCLES;
            end
            if (hold_off_left != 0) begin
                hold_off_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: stop a run that no longer makes progress.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Queue random ticks: mostly timer ticks with random buttons, some hold steps.
    task automatic queue_random_ticks(input int unsigned n);
        tick_item_t it;
        repeat (n) begin
            it.tick = ($urandom_range(99) < 85);
            it.up   = 1'($urandom_range(1));
            it.down = 1'($urandom_range(1));
            tick_backlog.push_back(it);
        end
    endtask

    // Wait until every transaction is delivered, then let the pipeline settle.
    task automatic wait_drained();
        do @(negedge aclk);
        while (tick_backlog.size() != 0 || s_valid || pending_views.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    // Write one register on the port and mirror it in the shadow copy.
    task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[CfgDataW-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_MIN_COUNT:   min_reg = val[7:0];
            CFG_MAX_COUNT:   max_reg = val[7:0];
            CFG_LOW_TICKS:   low_reg = val[9:0];
            CFG_PERIODS_UPD: ppu_reg = val[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int unsigned lo, input int unsigned hi,
                                 input int unsigned low_len, input int unsigned ppu);
        write_reg(CFG_MIN_COUNT, lo);
        write_reg(CFG_MAX_COUNT, hi);
        write_reg(CFG_LOW_TICKS, low_len);
        write_reg(CFG_PERIODS_UPD, ppu);
    endtask

    initial begin
        aclk           = 1'b0;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = CFG_MIN_COUNT;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_tick         = 1'b0;
        s_up_pressed   = 1'b0;
        s_down_pressed = 1'b0;
        m_ready        = 1'b0;
        hold_off_req   = 1'b0;
        tx_idle_pct    = 37;
        rx_idle_pct    = 60;
        mismatches     = 0;
        result_count   = 0;
        cycle_count    = 0;
        // Registers come out of reset at their defaults.
        min_reg = 8'd21;
        max_reg = 8'd104;
        low_reg = 10'd360;
        ppu_reg = 8'd50;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: every tick/up/down combination three times, starting with a
        // tick with both buttons held so the very first sample adds then subtracts.
        for (int i = 0; i < 24; i++) begin
            tick_backlog.push_back(tick_item_t'(~i[2:0]));
        end
        queue_random_ticks(150);
        wait_drained();

        // Zero low ticks and zero burst length act as one; the count wraps to a
        // zero pulse width, so ticks go straight to the low phase.
        apply_setting(0, 1, 0, 0);
        queue_random_ticks(200);
        wait_drained();

        // Swap the idle pattern: sender now idles more than the receiver.
        @(posedge aclk);
        tx_idle_pct <= 60;
        rx_idle_pct <= 37;

        // Short periods with a sample every period: wrap, increment, clamp.
        // Hold the receiver off for a long stretch so the input backs up.
        apply_setting(3, 12, 2, 1);
        queue_random_ticks(300);
        @(posedge aclk);
        hold_off_req <= 1'b1;
        wait_drained();

        // Maximum of zero forces a wrap to a large minimum at the next sample.
        apply_setting(200, 0, 1, 2);
        queue_random_ticks(250);
        wait_drained();

        // No idling from here on.
        @(posedge aclk);
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;

        // Minimum of zero with a wide pulse: the angle saturates at 180.
        apply_setting(0, 255, 1023, 255);
        queue_random_ticks(200);
        wait_drained();

        // Minimum above the count: the angle reads zero.
        apply_setting(255, 255, 5, 3);
        queue_random_ticks(200);
        wait_drained();

        // Wide count range so the digits walk through hundreds, tens and ones.
        apply_setting(10, 90, 3, 1);
        queue_random_ticks(350);
        wait_drained();
        repeat (8) @(posedge aclk);

        if (mismatches == 0 && pending_views.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: servo_pwm_with_angle_display.f
hw/rtl/spwm_pkg.sv
hw/rtl/servo_pwm_with_angle_display.sv
tb/sv/servo_pwm_with_angle_display_tb.sv
